[rtl/gbsp_pkg.sv]
// ----------------------------------------------------------------------------
// gbsp_pkg
// Shared types and constants for the BFS shortest-path engine.
// ----------------------------------------------------------------------------
package gbsp_pkg;

  localparam int NODE_COUNT = 64;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int CNT_W      = NODE_W + 1;   // counts 0..NODE_COUNT

  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [NODE_COUNT-1:0] row_t;

  // request action codes
  localparam logic ACT_ADD_EDGE = 1'b0;
  localparam logic ACT_QUERY    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_DEQ,
    ST_ROW_ADDR,
    ST_ROW_LOAD,
    ST_SCAN,
    ST_TRACE,
    ST_TRACE_WAIT,
    ST_EMIT_RD,
    ST_EMIT_LOAD,
    ST_OUT_WAIT
  } state_t;

endpackage

[rtl/gbsp_if.sv]
// ----------------------------------------------------------------------------
// gbsp_if
// Valid/ready channels: request in, path node out.
// ----------------------------------------------------------------------------
interface gbsp_in_if;
  logic                  valid;
  logic                  ready;
  logic                  action;
  gbsp_pkg::node_t       first_node;
  gbsp_pkg::node_t       second_node;

  modport source (output valid, output action, output first_node, output second_node,
                  input ready);
  modport sink   (input valid, input action, input first_node, input second_node,
                  output ready);
endinterface

interface gbsp_out_if;
  logic                  valid;
  logic                  ready;
  gbsp_pkg::node_t       path_node;
  logic                  found;
  logic                  last;

  modport source (output valid, output path_node, output found, output last,
                  input ready);
  modport sink   (input valid, input path_node, input found, input last,
                  output ready);
endinterface

[rtl/graph_bfs_shortest_path.sv]
// ----------------------------------------------------------------------------
// graph_bfs_shortest_path
// Undirected graph store with breadth-first shortest-path query.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        payload
//  in_req   in   valid / ready    action, first_node, second_node
//  out_rsp  out  valid / ready    path_node, found, last
//
// One request at a time; in_req.ready is high only in idle.
// Add edge: marks both endpoints present; when the endpoints differ, also a
//   read-modify-write of both adjacency rows through the single row memory.
// Query: setup seeds the source, then each dequeued node goes through queue read,
//   row address, row load and a scan that takes its newly found neighbors; trace back
//   reads each path node's predecessor; emission reads each path node from the
//   stack and holds it through any out_rsp stall.
// Reset (sync, active low) clears adjacency row valid bits and present marks
//   at once; no clearing pass. Output is held stable while out_rsp.ready is low.
// ----------------------------------------------------------------------------
module graph_bfs_shortest_path (
  input  logic                clk,
  input  logic                rst_n,
  gbsp_in_if.sink             in_req,
  gbsp_out_if.source          out_rsp
);

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  // adjacency rows: one row per node, valid bit per row stands for reset
  gbsp_pkg::row_t  adj_mem [gbsp_pkg::NODE_COUNT];
  // predecessor per node, written during search
  gbsp_pkg::node_t pred_mem [gbsp_pkg::NODE_COUNT];
  // BFS queue; reused as the path stack once the search is done
  gbsp_pkg::node_t queue_mem [gbsp_pkg::NODE_COUNT];

  gbsp_pkg::state_t state_r, state_nxt;

  gbsp_pkg::node_t a_r, a_nxt;
  gbsp_pkg::node_t b_r, b_nxt;
  gbsp_pkg::node_t cur_r, cur_nxt;
  gbsp_pkg::node_t node_r, node_nxt;
  gbsp_pkg::cnt_t  head_r, head_nxt;
  gbsp_pkg::cnt_t  tail_r, tail_nxt;
  gbsp_pkg::cnt_t  len_r, len_nxt;
  gbsp_pkg::cnt_t  rem_r, rem_nxt;
  gbsp_pkg::cnt_t  rem_dec;

  gbsp_pkg::row_t  present_r, present_nxt;
  gbsp_pkg::row_t  visited_r, visited_nxt;
  gbsp_pkg::row_t  pending_r, pending_nxt;
  gbsp_pkg::row_t  adj_valid_r;

  logic            out_valid_r, out_valid_nxt;
  gbsp_pkg::node_t out_node_r, out_node_nxt;
  logic            out_found_r, out_found_nxt;
  logic            out_last_r, out_last_nxt;

  // memory ports
  gbsp_pkg::node_t adj_raddr, adj_waddr;
  logic            adj_we;
  gbsp_pkg::row_t  adj_wdata, adj_rdata_r, adj_row;
  logic            adj_rvalid_r;

  gbsp_pkg::node_t pred_raddr, pred_waddr, pred_wdata, pred_rdata_r;
  logic            pred_we;

  gbsp_pkg::node_t q_raddr, q_waddr, q_wdata, q_rdata_r;
  logic            q_we;

  gbsp_pkg::node_t nb_idx;
  logic            in_fire;

  assign in_fire = in_req.valid && in_req.ready;
  assign rem_dec = rem_r - gbsp_pkg::CNT_W'(1);

  // a row never written reads as empty
  assign adj_row = adj_rvalid_r ? adj_rdata_r : '0;

  // lowest pending neighbor index
  always_comb begin
    nb_idx = '0;
    for (int i = gbsp_pkg::NODE_COUNT - 1; i >= 0; i--) begin
      if (pending_r[i]) begin
        nb_idx = gbsp_pkg::NODE_W'(i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Memories: one write port and one registered read port each
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rdata_r <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_valid_r  <= '0;
      adj_rvalid_r <= 1'b0;
    end else begin
      if (adj_we) begin
        adj_valid_r[adj_waddr] <= 1'b1;
      end
      adj_rvalid_r <= adj_valid_r[adj_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pred_we) begin
      pred_mem[pred_waddr] <= pred_wdata;
    end
    pred_rdata_r <= pred_mem[pred_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    q_rdata_r <= queue_mem[q_raddr];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbsp_pkg::ST_IDLE;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    cur_r       <= cur_nxt;
    node_r      <= node_nxt;
    head_r      <= head_nxt;
    tail_r      <= tail_nxt;
    len_r       <= len_nxt;
    rem_r       <= rem_nxt;
    visited_r   <= visited_nxt;
    pending_r   <= pending_nxt;
    out_node_r  <= out_node_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    node_nxt      = node_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    present_nxt   = present_r;
    visited_nxt   = visited_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r;
    out_node_nxt  = out_node_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;

    in_req.ready  = 1'b0;

    adj_raddr  = '0;
    adj_we     = 1'b0;
    adj_waddr  = '0;
    adj_wdata  = '0;
    pred_raddr = '0;
    pred_we    = 1'b0;
    pred_waddr = '0;
    pred_wdata = '0;
    q_raddr    = '0;
    q_we       = 1'b0;
    q_waddr    = '0;
    q_wdata    = '0;

    unique case (state_r)
      gbsp_pkg::ST_IDLE: begin
        in_req.ready = 1'b1;
        if (in_fire) begin
          a_nxt = in_req.first_node;
          b_nxt = in_req.second_node;
          if (in_req.action == gbsp_pkg::ACT_ADD_EDGE) begin
            present_nxt = present_r | (gbsp_pkg::row_t'(1) << in_req.first_node)
                                    | (gbsp_pkg::row_t'(1) << in_req.second_node);
            if (in_req.first_node != in_req.second_node) begin
              adj_raddr = in_req.first_node;
              state_nxt = gbsp_pkg::ST_ADD_A;
            end
          end else if (present_r[in_req.first_node] && present_r[in_req.second_node]) begin
            // seed the search with the source
            visited_nxt = gbsp_pkg::row_t'(1) << in_req.first_node;
            q_we        = 1'b1;
            q_waddr     = '0;
            q_wdata     = in_req.first_node;
            pred_we     = 1'b1;
            pred_waddr  = in_req.first_node;
            pred_wdata  = in_req.first_node;
            head_nxt    = '0;
            tail_nxt    = gbsp_pkg::cnt_t'(1);
            state_nxt   = gbsp_pkg::ST_DEQ;
          end else begin
            out_valid_nxt = 1'b1;
            out_node_nxt  = '0;
            out_found_nxt = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = gbsp_pkg::ST_OUT_WAIT;
          end
        end
      end

      gbsp_pkg::ST_ADD_A: begin
        adj_we    = 1'b1;
        adj_waddr = a_r;
        adj_wdata = adj_row | (gbsp_pkg::row_t'(1) << b_r);
        adj_raddr = b_r;
        state_nxt = gbsp_pkg::ST_ADD_B;
      end

      gbsp_pkg::ST_ADD_B: begin
        adj_we    = 1'b1;
        adj_waddr = b_r;
        adj_wdata = adj_row | (gbsp_pkg::row_t'(1) << a_r);
        state_nxt = gbsp_pkg::ST_IDLE;
      end

      gbsp_pkg::ST_DEQ: begin
        if (head_r == tail_r) begin
          if (visited_r[b_r]) begin
            node_nxt  = b_r;
            len_nxt   = '0;
            state_nxt = gbsp_pkg::ST_TRACE;
          end else begin
            out_valid_nxt = 1'b1;
            out_node_nxt  = '0;
            out_found_nxt = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = gbsp_pkg::ST_OUT_WAIT;
          end
        end else begin
          q_raddr   = head_r[gbsp_pkg::NODE_W-1:0];
          head_nxt  = head_r + gbsp_pkg::CNT_W'(1);
          state_nxt = gbsp_pkg::ST_ROW_ADDR;
        end
      end

      gbsp_pkg::ST_ROW_ADDR: begin
        cur_nxt   = q_rdata_r;
        adj_raddr = q_rdata_r;
        state_nxt = gbsp_pkg::ST_ROW_LOAD;
      end

      gbsp_pkg::ST_ROW_LOAD: begin
        pending_nxt = adj_row & ~visited_r;
        state_nxt   = gbsp_pkg::ST_SCAN;
      end

      gbsp_pkg::ST_SCAN: begin
        if (pending_r == '0) begin
          state_nxt = gbsp_pkg::ST_DEQ;
        end else begin
          // one new neighbor per cycle, ascending index
          visited_nxt = visited_r | (gbsp_pkg::row_t'(1) << nb_idx);
          pending_nxt = pending_r & ~(gbsp_pkg::row_t'(1) << nb_idx);
          pred_we     = 1'b1;
          pred_waddr  = nb_idx;
          pred_wdata  = cur_r;
          q_we        = 1'b1;
          q_waddr     = tail_r[gbsp_pkg::NODE_W-1:0];
          q_wdata     = nb_idx;
          tail_nxt    = tail_r + gbsp_pkg::CNT_W'(1);
        end
      end

      gbsp_pkg::ST_TRACE: begin
        // push onto path stack, destination first
        q_we    = 1'b1;
        q_waddr = len_r[gbsp_pkg::NODE_W-1:0];
        q_wdata = node_r;
        len_nxt = len_r + gbsp_pkg::CNT_W'(1);
        if (node_r == a_r) begin
          rem_nxt   = len_r + gbsp_pkg::CNT_W'(1);
          state_nxt = gbsp_pkg::ST_EMIT_RD;
        end else begin
          pred_raddr = node_r;
          state_nxt  = gbsp_pkg::ST_TRACE_WAIT;
        end
      end

      gbsp_pkg::ST_TRACE_WAIT: begin
        node_nxt  = pred_rdata_r;
        state_nxt = gbsp_pkg::ST_TRACE;
      end

      gbsp_pkg::ST_EMIT_RD: begin
        q_raddr   = rem_dec[gbsp_pkg::NODE_W-1:0];
        rem_nxt   = rem_dec;
        state_nxt = gbsp_pkg::ST_EMIT_LOAD;
      end

      gbsp_pkg::ST_EMIT_LOAD: begin
        out_valid_nxt = 1'b1;
        out_node_nxt  = q_rdata_r;
        out_found_nxt = 1'b1;
        out_last_nxt  = (rem_r == '0);
        state_nxt     = gbsp_pkg::ST_OUT_WAIT;
      end

      gbsp_pkg::ST_OUT_WAIT: begin
        if (out_rsp.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = gbsp_pkg::ST_IDLE;
          end else begin
            // prefetch next stack entry while this one leaves
            q_raddr   = rem_dec[gbsp_pkg::NODE_W-1:0];
            rem_nxt   = rem_dec;
            state_nxt = gbsp_pkg::ST_EMIT_LOAD;
          end
        end
      end

      default: begin
        state_nxt = gbsp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.path_node = out_node_r;
  assign out_rsp.found     = out_found_r;
  assign out_rsp.last      = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // a not-found response is always the only, hence last, one
  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && !out_rsp.found |-> out_rsp.last)
    else $error("not-found response without last");

  // no new request while a response is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> !out_rsp.valid)
    else $error("request accepted with response pending");

  // final response taken returns the engine to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.ready && out_rsp.last |=> in_req.ready)
    else $error("engine not idle after last response");

  // queue head never passes tail during search
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gbsp_pkg::ST_DEQ || state_r == gbsp_pkg::ST_SCAN) |-> head_r <= tail_r)
    else $error("queue head beyond tail");
`endif

endmodule
